>>> rtl/assert_macros.svh
// Concurrent assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/eeh_pkg.sv
// Package of the emergency event history: sizes, item kinds, entry and control types.
package eeh_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int LEFT_W = $clog2(HISTORY_DEPTH + 1);

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [31:0] sequence_no;
        logic [6:0]  node;
        logic [15:0] code;
        logic [7:0]  err_reg;
        logic [39:0] manufacturer;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic rec;      // record transfer accepted
        logic clr;      // clear transfer accepted
        logic load;     // query accepted: load scan start point
        logic rd;       // read the current slot
        logic step;     // move to the next older slot
        logic none;     // deliver a "not found" result
        logic found;    // deliver the entry just read
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cand_zero;
        logic left_zero;
        logic entry_ok;
        logic node_hit;
    } t_status;

endpackage

>>> rtl/emergency_event_history.sv
// Top level of the emergency event history: controller, datapath and checks.
//
// Command channel: an item transfers at a rising edge with start high and busy low.
//   i_kind selects record (0), query (1) or clear (2); kind 3 is dropped.
// Record: node 1..127 is stored under the next sequence number;
//   node 0 is dropped. busy stays low, so another item may follow at once.
// Clear: empties the history, busy stays low.
// Query: busy rises for the scan, which walks back from the newest event,
//   each entry taking a registered event-memory read and then a compare,
//   over at most HISTORY_DEPTH entries. The scan ends when an entry read
//   decides the result or when it runs out of entries; an empty history
//   answers not found without reading an entry.
// Result channel: o_result_valid is high for exactly one cycle with the result
//   fields; the receiver cannot stall it. busy is already low in that cycle,
//   so the next item may transfer while the result is shown.
// o_status 0 means an event was found; 1 means none, with all fields zero.
// Reset (i_rst_n low, synchronous) empties the history, returns to idle and
//   drops any scan in progress. Per-slot valid flags clear at once.
`include "assert_macros.svh"

module emergency_event_history (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_node_id,
    input  logic [15:0] i_error_code,
    input  logic [7:0]  i_error_register,
    input  logic [39:0] i_manufacturer_data,
    output logic        o_result_valid,
    output logic        o_status,
    output logic [6:0]  o_found_node,
    output logic [15:0] o_found_code,
    output logic [7:0]  o_found_register,
    output logic [39:0] o_found_manufacturer,
    output logic [31:0] o_found_sequence
);

    eeh_pkg::t_cmd    w_cmd;
    eeh_pkg::t_status w_status;

    // sequencing of transfers and the query scan
    eeh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_kind   (i_kind),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_result_valid)
    );

    // storage, sequence counter, scan pointers and result registers
    eeh_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_node_id            (i_node_id),
        .i_error_code         (i_error_code),
        .i_error_register     (i_error_register),
        .i_manufacturer_data  (i_manufacturer_data),
        .o_status             (w_status),
        .o_res_status         (o_status),
        .o_found_node         (o_found_node),
        .o_found_code         (o_found_code),
        .o_found_register     (o_found_register),
        .o_found_manufacturer (o_found_manufacturer),
        .o_found_sequence     (o_found_sequence)
    );

    // busy is already low whenever a result is shown
    `ASSERT_IMPLY(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy)
    // an accepted query always starts a scan
    `ASSERT_NEXT(a_query_goes_busy, i_clk, i_rst_n,
        start && !busy && (i_kind == eeh_pkg::KIND_QUERY), busy)
    // record, clear or dropped kinds never produce a result
    `ASSERT_NEXT(a_no_result_other, i_clk, i_rst_n,
        start && !busy && (i_kind != eeh_pkg::KIND_QUERY), !o_result_valid)
    // a found event always carries a real node and sequence
    `ASSERT_IMPLY(a_found_is_real, i_clk, i_rst_n, o_result_valid && !o_status,
        (o_found_node != 7'd0) && (o_found_sequence != 32'd0))
    // nothing found means all fields are zero
    `ASSERT_IMPLY(a_none_is_zero, i_clk, i_rst_n, o_result_valid && o_status,
        (o_found_node == 7'd0) && (o_found_sequence == 32'd0))

endmodule

>>> rtl/eeh_ctrl.sv
// Controller of the emergency event history: accepts items and sequences the query scan.
module eeh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_kind,
    input  eeh_pkg::t_status i_status,
    output eeh_pkg::t_cmd   o_cmd,
    output logic            o_busy,
    output logic            o_strobe
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;
    logic   w_accept;
    logic   w_scan_end;

    assign w_accept   = (r_state == S_IDLE) && i_start;
    assign w_scan_end = i_status.cand_zero || i_status.left_zero;

    always_comb begin
        o_cmd       = '0;
        o_cmd.rec   = w_accept && (i_kind == eeh_pkg::KIND_RECORD);
        o_cmd.clr   = w_accept && (i_kind == eeh_pkg::KIND_CLEAR);
        o_cmd.load  = w_accept && (i_kind == eeh_pkg::KIND_QUERY);
        o_cmd.rd    = (r_state == S_SCAN) && !w_scan_end;
        o_cmd.none  = ((r_state == S_SCAN) && w_scan_end)
                    || ((r_state == S_CHECK) && !i_status.entry_ok);
        o_cmd.found = (r_state == S_CHECK) && i_status.entry_ok && i_status.node_hit;
        o_cmd.step  = (r_state == S_CHECK) && i_status.entry_ok && !i_status.node_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= S_SCAN;
                        r_busy  <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                        r_strobe <= 1'b1;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (o_cmd.step) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                        r_strobe <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

>>> rtl/eeh_datapath.sv
// Datapath of the emergency event history: event memory, sequence, scan registers, result.
module eeh_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eeh_pkg::t_cmd     i_cmd,
    input  logic [6:0]        i_node_id,
    input  logic [15:0]       i_error_code,
    input  logic [7:0]        i_error_register,
    input  logic [39:0]       i_manufacturer_data,
    output eeh_pkg::t_status  o_status,
    output logic              o_res_status,
    output logic [6:0]        o_found_node,
    output logic [15:0]       o_found_code,
    output logic [7:0]        o_found_register,
    output logic [39:0]       o_found_manufacturer,
    output logic [31:0]       o_found_sequence
);

    localparam logic [eeh_pkg::SLOT_W-1:0] LAST_SLOT =
        eeh_pkg::SLOT_W'(eeh_pkg::HISTORY_DEPTH - 1);

    eeh_pkg::t_entry r_mem [eeh_pkg::HISTORY_DEPTH];
    eeh_pkg::t_entry r_rd;
    eeh_pkg::t_entry w_wr;
    logic                          r_rd_valid;
    logic [eeh_pkg::HISTORY_DEPTH-1:0] r_valid;
    logic [31:0]                   r_latest;
    logic [eeh_pkg::SLOT_W-1:0]    r_head;
    logic [6:0]                    r_filter;
    logic [31:0]                   r_cand;
    logic [eeh_pkg::SLOT_W-1:0]    r_slot;
    logic [eeh_pkg::LEFT_W-1:0]    r_left;
    logic                          r_res_status;
    eeh_pkg::t_entry               r_res;

    logic [31:0]                   n_seq;
    logic [eeh_pkg::SLOT_W-1:0]    n_slot;
    logic                          w_write;

    // next sequence wraps past zero to 1; sequence 1 always lands in slot 0
    always_comb begin
        n_seq = r_latest + 32'd1;
        if (n_seq == 32'd0) begin
            n_seq = 32'd1;
        end
        if (n_seq == 32'd1 || r_head == LAST_SLOT) begin
            n_slot = '0;
        end else begin
            n_slot = r_head + eeh_pkg::SLOT_W'(1);
        end
    end

    assign w_write           = i_cmd.rec && (i_node_id != 7'd0);
    assign w_wr.sequence_no  = n_seq;
    assign w_wr.node         = i_node_id;
    assign w_wr.code         = i_error_code;
    assign w_wr.err_reg      = i_error_register;
    assign w_wr.manufacturer = i_manufacturer_data;

    // event memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[n_slot] <= w_wr;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_latest <= 32'd0;
            r_head   <= '0;
        end else if (i_cmd.clr) begin
            r_valid  <= '0;
            r_latest <= 32'd0;
            r_head   <= '0;
        end else if (w_write) begin
            r_valid[n_slot] <= 1'b1;
            r_latest        <= n_seq;
            r_head          <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_filter <= i_node_id;
            r_cand   <= r_latest;
            r_slot   <= r_head;
            r_left   <= eeh_pkg::LEFT_W'(eeh_pkg::HISTORY_DEPTH);
        end
        if (i_cmd.rd) begin
            r_rd_valid <= r_valid[r_slot];
            r_left     <= r_left - eeh_pkg::LEFT_W'(1);
        end
        if (i_cmd.step) begin
            r_cand <= (r_cand > 32'd1) ? r_cand - 32'd1 : 32'd0;
            r_slot <= (r_slot == '0) ? LAST_SLOT : r_slot - eeh_pkg::SLOT_W'(1);
        end
        if (i_cmd.none) begin
            r_res_status <= 1'b1;
            r_res        <= '0;
        end else if (i_cmd.found) begin
            r_res_status <= 1'b0;
            r_res        <= r_rd;
        end
    end

    assign o_status.cand_zero = (r_cand == 32'd0);
    assign o_status.left_zero = (r_left == '0);
    assign o_status.entry_ok  = r_rd_valid && (r_rd.sequence_no == r_cand);
    assign o_status.node_hit  = (r_filter == 7'd0) || (r_rd.node == r_filter);

    assign o_res_status         = r_res_status;
    assign o_found_node         = r_res.node;
    assign o_found_code         = r_res.code;
    assign o_found_register     = r_res.err_reg;
    assign o_found_manufacturer = r_res.manufacturer;
    assign o_found_sequence     = r_res.sequence_no;

endmodule
